// ===== rtl/core/atmf_pkg.sv =====
package atmf_pkg;

    localparam int CFG_W         = 11;
    localparam int CNT_W         = 22;
    localparam int ROW_SLOT_BITS = 4;
    localparam int HEIGHT_MAX    = 1024;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] filtered;
        logic       last_of_frame;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_TRIM   = 2'd3
    } cfg_index_t;

    // effective frame settings after clamping
    typedef struct packed {
        logic [10:0] width;
        logic [10:0] height;
        logic [1:0]  radius;
        logic [4:0]  trim;
    } frame_cfg_t;

    // one output pixel to be computed
    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic        last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_GATHER,
        BK_SUM,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

// ===== rtl/core/atmf_queue.sv =====
module atmf_queue
    import atmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head,
    output queue_status_t status
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

// ===== rtl/core/atmf_front.sv =====
module atmf_front
    import atmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    restart,
    input  frame_cfg_t                              cfg,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  in_item_t                                in_data,
    input  queue_status_t                           q_status,
    input  logic                                    back_idle,
    output logic                                    push,
    output job_t                                    push_job,
    output logic                                    wr_en,
    output logic [ROW_SLOT_BITS+$clog2(MAX_WIDTH)-1:0] wr_addr,
    output logic [7:0]                              wr_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int EXT_W    = 13;

    logic [CNT_W-1:0]    in_count_reg;
    logic [CNT_W-1:0]    in_count_next;
    logic [CNT_W-1:0]    out_count_reg;
    logic [CNT_W-1:0]    out_count_next;
    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;
    logic [10:0]         row_reg;
    logic [10:0]         row_next;
    logic [10:0]         ox_reg;
    logic [10:0]         ox_next;
    logic [10:0]         oy_reg;
    logic [10:0]         oy_next;

    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lat;
    logic [12:0]      rw;
    logic             input_phase;
    logic             frame_start;
    logic             accept;
    logic             is_pix;
    logic             emit;
    logic             drop;
    logic             last;
    logic [EXT_W-1:0] col_inc;
    logic [EXT_W-1:0] ox_inc;

    assign total = CNT_W'(cfg.width) * CNT_W'(cfg.height);
    assign rw    = (cfg.radius[0] ? 13'(cfg.width) : 13'd0)
                 + (cfg.radius[1] ? {1'b0, cfg.width, 1'b0} : 13'd0);
    assign lat   = CNT_W'(rw) + CNT_W'(cfg.radius);

    assign input_phase = (in_count_reg < total);
    assign frame_start = (in_count_reg == '0) && (out_count_reg == '0);
    // a new frame waits until the back end no longer reads the old rows
    assign in_ready    = !q_status.full && (!frame_start || (q_status.empty && back_idle));
    assign accept      = in_valid && in_ready;

    assign is_pix = input_phase && !in_data.mode;
    assign emit   = input_phase ? (is_pix && ((in_count_reg + 1'b1) > lat))
                                : (out_count_reg < total);
    assign drop   = !input_phase && !(out_count_reg < total);
    assign last   = ((out_count_reg + 1'b1) == total);

    assign col_inc = EXT_W'(col_reg) + 13'd1;
    assign ox_inc  = EXT_W'(ox_reg) + 13'd1;

    assign wr_en   = accept && is_pix;
    assign wr_addr = {row_reg[ROW_SLOT_BITS-1:0], col_reg};
    assign wr_data = in_data.pixel;

    assign push          = accept && emit;
    assign push_job.x    = ox_reg;
    assign push_job.y    = oy_reg;
    assign push_job.last = last;

    always_comb
    begin
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        if (accept)
        begin
            if (is_pix)
            begin
                in_count_next = in_count_reg + 1'b1;
                if (col_inc >= EXT_W'(cfg.width))
                begin
                    col_next = '0;
                    row_next = row_reg + 11'd1;
                end
                else
                begin
                    col_next = col_inc[COL_BITS-1:0];
                end
            end
            if (emit)
            begin
                out_count_next = out_count_reg + 1'b1;
                if (ox_inc >= EXT_W'(cfg.width))
                begin
                    ox_next = '0;
                    oy_next = oy_reg + 11'd1;
                end
                else
                begin
                    ox_next = ox_inc[10:0];
                end
            end
            if ((emit && last) || drop)
            begin
                in_count_next  = '0;
                out_count_next = '0;
                col_next       = '0;
                row_next       = '0;
                ox_next        = '0;
                oy_next        = '0;
            end
        end
        if (restart)
        begin
            in_count_next  = '0;
            out_count_next = '0;
            col_next       = '0;
            row_next       = '0;
            ox_next        = '0;
            oy_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
        end
        else
        begin
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
        end
    end

endmodule

// ===== rtl/core/atmf_back.sv =====
module atmf_back
    import atmf_pkg::*;
#(
    parameter int MAX_WINDOW = 5,
    parameter int MAX_WIDTH  = 1024
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  frame_cfg_t                              cfg,
    input  logic                                    wr_en,
    input  logic [ROW_SLOT_BITS+$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [7:0]                              wr_data,
    input  queue_status_t                           q_status,
    input  job_t                                    q_head,
    output logic                                    pop,
    output logic                                    idle,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output out_item_t                               out_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ADDR_W   = ROW_SLOT_BITS + COL_BITS;
    localparam int DEPTH    = (1 << ROW_SLOT_BITS) * MAX_WIDTH;
    localparam int RAD_CAP  = (MAX_WINDOW - 1) / 2;
    localparam int SIDE_MAX = 2 * RAD_CAP + 1;
    localparam int NTAPS    = SIDE_MAX * SIDE_MAX;
    localparam int TAP_W    = $clog2(NTAPS + 1);
    localparam int IDX_W    = (NTAPS > 1) ? $clog2(NTAPS) : 1;
    localparam int SIDE_W   = $clog2(SIDE_MAX + 1);
    localparam int SUM_W    = $clog2(NTAPS * 255 + 1);
    localparam int BIT_W    = $clog2(SUM_W + 1);
    localparam int EXT_W    = 13;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    back_state_t state_reg;
    back_state_t state_next;

    job_t              job_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [TAP_W-1:0]  n_reg;
    logic [TAP_W-1:0]  lo_reg;
    logic [TAP_W-1:0]  hi_reg;
    logic [TAP_W-1:0]  m_reg;
    logic [SIDE_W-1:0] ti_reg;
    logic [SIDE_W-1:0] tj_reg;
    logic [TAP_W-1:0]  issued_reg;
    logic              pend_reg;
    logic              ok_reg;
    logic [TAP_W-1:0]  cnt_reg;
    logic [7:0]        s_reg [NTAPS];
    logic [7:0]        s_next [NTAPS];
    logic [TAP_W-1:0]  k_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [TAP_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [6:0]        side_w;
    logic [6:0]        n_w;
    logic [6:0]        d_w;
    logic [EXT_W-1:0]  yy;
    logic [EXT_W-1:0]  xx;
    logic [EXT_W-1:0]  yr;
    logic [EXT_W-1:0]  xr;
    logic              tap_ok;
    logic              issue;
    logic [7:0]        ins_val;
    logic [NTAPS-1:0]  gt;
    logic              keep;
    logic [TAP_W:0]    shifted;
    logic              load_out;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // window size and trim bounds for the current settings
    always_comb
    begin
        side_w = 7'({cfg.radius, 1'b1});
        n_w    = side_w * side_w;
        d_w    = 7'(cfg.trim[4:1]);
        if ({d_w[5:0], 1'b0} >= n_w)
        begin
            d_w = (n_w - 7'd1) >> 1;
        end
    end

    // window tap address and frame bounds check
    assign yy     = EXT_W'(job_reg.y) + EXT_W'(ti_reg);
    assign xx     = EXT_W'(job_reg.x) + EXT_W'(tj_reg);
    assign yr     = yy - EXT_W'(cfg.radius);
    assign xr     = xx - EXT_W'(cfg.radius);
    assign tap_ok = (yy >= EXT_W'(cfg.radius)) && (yr < EXT_W'(cfg.height))
                 && (xx >= EXT_W'(cfg.radius)) && (xr < EXT_W'(cfg.width));
    assign rd_addr = {yr[ROW_SLOT_BITS-1:0], xr[COL_BITS-1:0]};
    assign issue   = (state_reg == BK_GATHER) && (issued_reg < n_reg);

    // insertion of one value into the sorted window per cycle
    assign ins_val = ok_reg ? rd_data_reg : 8'd0;
    always_comb
    begin
        for (int k = 0; k < NTAPS; k++)
        begin
            gt[k] = (TAP_W'(k) >= cnt_reg) || (s_reg[k] > ins_val);
        end
        for (int k = 0; k < NTAPS; k++)
        begin
            if (!gt[k])
            begin
                s_next[k] = s_reg[k];
            end
            else if (k > 0 && gt[(k > 0) ? k - 1 : 0])
            begin
                s_next[k] = s_reg[(k > 0) ? k - 1 : 0];
            end
            else
            begin
                s_next[k] = ins_val;
            end
        end
    end

    assign keep     = (k_reg >= lo_reg) && (k_reg < hi_reg);
    assign sum_next = sum_reg + (keep ? SUM_W'(s_reg[k_reg[IDX_W-1:0]]) : SUM_W'(0));
    assign shifted  = {rem_reg, quo_reg[SUM_W-1]};
    assign load_out = (state_reg == BK_DONE) && (!out_valid_reg || out_ready);

    assign pop  = (state_reg == BK_IDLE) && !q_status.empty;
    assign idle = (state_reg == BK_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = BK_SETUP;
                end
            end
            BK_SETUP:
            begin
                state_next = BK_GATHER;
            end
            BK_GATHER:
            begin
                if ((issued_reg == n_reg) && !pend_reg)
                begin
                    state_next = BK_SUM;
                end
            end
            BK_SUM:
            begin
                if ((k_reg + 1'b1) == n_reg)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (bit_reg == BIT_W'(1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (load_out)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= tap_ok;
        if (pop)
        begin
            job_reg <= q_head;
        end
        if (state_reg == BK_SETUP)
        begin
            side_reg   <= SIDE_W'(side_w);
            n_reg      <= TAP_W'(n_w);
            lo_reg     <= TAP_W'(d_w);
            hi_reg     <= TAP_W'(n_w - d_w);
            m_reg      <= TAP_W'(n_w - {d_w[5:0], 1'b0});
            ti_reg     <= '0;
            tj_reg     <= '0;
            issued_reg <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            sum_reg    <= '0;
        end
        if (issue)
        begin
            issued_reg <= issued_reg + 1'b1;
            if ((tj_reg + 1'b1) == side_reg)
            begin
                tj_reg <= '0;
                ti_reg <= ti_reg + 1'b1;
            end
            else
            begin
                tj_reg <= tj_reg + 1'b1;
            end
        end
        if ((state_reg == BK_GATHER) && pend_reg)
        begin
            s_reg   <= s_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == BK_SUM)
        begin
            sum_reg <= sum_next;
            k_reg   <= k_reg + 1'b1;
            if ((k_reg + 1'b1) == n_reg)
            begin
                quo_reg <= sum_next;
                rem_reg <= '0;
                bit_reg <= BIT_W'(SUM_W);
            end
        end
        if (state_reg == BK_DIV)
        begin
            bit_reg <= bit_reg - 1'b1;
            if (shifted >= (TAP_W + 1)'(m_reg))
            begin
                rem_reg <= TAP_W'(shifted - (TAP_W + 1)'(m_reg));
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[TAP_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (load_out)
        begin
            out_data_reg.filtered      <= quo_reg[7:0];
            out_data_reg.last_of_frame <= job_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/alpha_trimmed_mean_filter_top.sv =====
// throughput: the back end takes one job at a time and pops the next only
// after its result is loaded; each result reads n = (2*radius+1)^2 window taps
// through the single line store read port and then runs the bit-serial divider
// reset: asynchronous, active low; counters clear, registers take 640x480,
// radius 1, trim 3; line store contents are not cleared
module alpha_trimmed_mean_filter_top
    import atmf_pkg::*;
#(
    parameter int MAX_WINDOW = 5,
    parameter int MAX_WIDTH  = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int ADDR_W  = ROW_SLOT_BITS + $clog2(MAX_WIDTH);
    localparam int RAD_CAP = (MAX_WINDOW - 1) / 2;
    localparam logic [10:0] WIDTH_CAP = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);
    localparam logic [1:0]  RAD_CAP_L = 2'(RAD_CAP);

    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [1:0]  radius_reg;
    logic [4:0]  trim_reg;
    logic        cfg_we;

    frame_cfg_t    eff;
    queue_status_t q_status;
    job_t          push_job;
    job_t          q_head;
    logic          push;
    logic          pop;
    logic          back_idle;
    logic          wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
            radius_reg <= 2'd1;
            trim_reg   <= 5'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_RADIUS: radius_reg <= cfg_data[1:0];
                REG_TRIM:   trim_reg   <= cfg_data[4:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        eff.width = width_reg;
        if (width_reg == 11'd0)
        begin
            eff.width = 11'd1;
        end
        else if (width_reg > WIDTH_CAP)
        begin
            eff.width = WIDTH_CAP;
        end
        eff.height = height_reg;
        if (height_reg == 11'd0)
        begin
            eff.height = 11'd1;
        end
        else if (height_reg > 11'(HEIGHT_MAX))
        begin
            eff.height = 11'(HEIGHT_MAX);
        end
        eff.radius = (radius_reg > RAD_CAP_L) ? RAD_CAP_L : radius_reg;
        eff.trim   = trim_reg;
    end

    atmf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_we),
        .cfg       (eff),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_status  (q_status),
        .back_idle (back_idle),
        .push      (push),
        .push_job  (push_job),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    atmf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_head),
        .status   (q_status)
    );

    atmf_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (eff),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_status  (q_status),
        .q_head    (q_head),
        .pop       (pop),
        .idle      (back_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/atmf_checker.sv =====
module atmf_checker
    import atmf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a presented result carries known data
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result has unknown bits");

endmodule

bind alpha_trimmed_mean_filter_top atmf_checker u_atmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/alpha_trimmed_mean_filter_top_test.sv =====
`timescale 1ns / 1ps

module alpha_trimmed_mean_filter_top_test;
    import atmf_pkg::*;

    localparam int STALL_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    alpha_trimmed_mean_filter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [10:0] reg_width  = 11'd640;
    logic [10:0] reg_height = 11'd480;
    logic [1:0]  reg_radius = 2'd1;
    logic [4:0]  reg_trim   = 5'd3;
    logic [7:0]  row_mem [16][1024];
    int          col_in;
    int          row_in;
    int          pixels_out;

    in_item_t    pending_q [$];
    out_item_t   expected_q [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    int          hold_left;
    int          idle_cycles;
    int          mismatches;
    int          results_seen;
    int          frames_run;
    int          random_items;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int eff_width();
        if (reg_width == 0) return 1;
        if (reg_width > 1024) return 1024;
        return reg_width;
    endfunction

    function automatic int eff_height();
        if (reg_height == 0) return 1;
        if (reg_height > HEIGHT_MAX) return HEIGHT_MAX;
        return reg_height;
    endfunction

    function automatic int eff_radius();
        return (reg_radius > 2) ? 2 : reg_radius;
    endfunction

    function automatic logic [7:0] trimmed_mean(int o, int w, int h, int r);
        logic [7:0] taps [25];
        logic [7:0] v;
        int x;
        int y;
        int side;
        int n;
        int k;
        int j;
        int d;
        int sum;
        x = o % w;
        y = o / w;
        side = 2 * r + 1;
        n = side * side;
        k = 0;
        sum = 0;
        for (int i = 0; i < side; i++)
        begin
            for (int c = 0; c < side; c++)
            begin
                int yy;
                int xx;
                yy = y + i - r;
                xx = x + c - r;
                if (yy >= 0 && yy < h && xx >= 0 && xx < w)
                    taps[k] = row_mem[yy % 16][xx];
                else
                    taps[k] = 8'd0;
                k++;
            end
        end
        for (int i = 1; i < n; i++)
        begin
            v = taps[i];
            j = i;
            while (j > 0 && taps[j-1] > v)
            begin
                taps[j] = taps[j-1];
                j--;
            end
            taps[j] = v;
        end
        d = reg_trim / 2;
        if (2 * d >= n) d = (n - 1) / 2;
        for (int i = d; i < n - d; i++) sum += taps[i];
        return 8'(sum / (n - 2 * d));
    endfunction

    function automatic void restart_frame();
        col_in = 0;
        row_in = 0;
        pixels_out = 0;
    endfunction

    function automatic void predict_filter(in_item_t it);
        out_item_t res;
        int w;
        int h;
        int r;
        int total;
        int n;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        total = w * h;
        if (row_in < h)
        begin
            if (it.mode) return;
            if (col_in >= w) col_in = 0;
            row_mem[row_in % 16][col_in] = it.pixel;
            col_in++;
            if (col_in >= w)
            begin
                col_in = 0;
                row_in++;
            end
            n = row_in * w + col_in;
            if (n <= r * w + r) return;
        end
        if (pixels_out >= total)
        begin
            restart_frame();
            return;
        end
        res.filtered = trimmed_mean(pixels_out, w, h, r);
        res.last_of_frame = (pixels_out + 1 == total);
        expected_q.insert(expected_q.size(), res);
        pixels_out++;
        if (pixels_out >= total) restart_frame();
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready) predict_filter(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result filtered=%0d last=%0b",
                                 out_data.filtered, out_data.last_of_frame);
                end
                else
                begin
                    out_item_t exp_res;
                    exp_res = expected_q.pop_front();
                    if (exp_res.filtered !== out_data.filtered ||
                        exp_res.last_of_frame !== out_data.last_of_frame)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected filtered=%0d last=%0b, got %0d %0b",
                                     exp_res.filtered, exp_res.last_of_frame,
                                     out_data.filtered, out_data.last_of_frame);
                    end
                end
            end
            if (hold_request && hold_left == 0)
            begin
                hold_request <= 1'b0;
                hold_left    <= HOLD_CYCLES;
                out_ready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH:  reg_width  = value;
            REG_HEIGHT: reg_height = value;
            REG_RADIUS: reg_radius = value[1:0];
            REG_TRIM:   reg_trim   = value[4:0];
            default:    ;
        endcase
        restart_frame();
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_pixel(int style);
        case (style)
            0: return ($urandom_range(1)) ? 8'hFF : 8'h00;
            1: return 8'($urandom_range(3) * 85);
            default: return 8'($urandom);
        endcase
    endfunction

    // one frame of pixels plus the drains that flush it; stray drains and
    // surplus pixels are sprinkled in when noisy
    task automatic queue_frame(int style, bit noisy, output int count);
        in_item_t it;
        int w;
        int h;
        int r;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        count = 0;
        for (int p = 0; p < w * h; p++)
        begin
            if (noisy && $urandom_range(19) == 0)
            begin
                it.mode  = 1'b1;
                it.pixel = 8'($urandom);
                pending_q.insert(pending_q.size(), it);
            end
            it.mode  = 1'b0;
            it.pixel = pick_pixel(style);
            pending_q.insert(pending_q.size(), it);
            count++;
        end
        for (int d = 0; d < r * w + r; d++)
        begin
            it.mode  = (noisy && $urandom_range(3) == 0) ? 1'b0 : 1'b1;
            it.pixel = 8'($urandom);
            pending_q.insert(pending_q.size(), it);
            count++;
        end
        if (noisy && $urandom_range(3) == 0)
        begin
            // drain at the start of the next frame, no result
            it.mode  = 1'b1;
            it.pixel = 8'($urandom);
            pending_q.insert(pending_q.size(), it);
        end
    endtask

    task automatic run_setting(logic [10:0] w, logic [10:0] h, logic [1:0] r,
                               logic [4:0] t, int frames, int style, bit noisy,
                               output int count);
        int c;
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RADIUS, 11'(r));
        write_reg(REG_TRIM, 11'(t));
        count = 0;
        for (int f = 0; f < frames; f++)
        begin
            queue_frame(style, noisy, c);
            count += c;
            frames_run++;
        end
    endtask

    initial
    begin
        int c;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_request = 1'b0;
        idle_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        frames_run = 0;
        random_items = 0;
        send_idle_pct = 12;
        recv_idle_pct = 61;
        restart_frame();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed settings: single pixel, zero sizes, oversized radius and trim
        run_setting(11'd1, 11'd1, 2'd0, 5'd0, 1, 0, 1'b0, c);
        run_setting(11'd0, 11'd0, 2'd1, 5'd2, 1, 0, 1'b0, c);
        run_setting(11'd3, 11'd3, 2'd1, 5'd0, 1, 0, 1'b0, c);
        run_setting(11'd4, 11'd3, 2'd1, 5'd24, 1, 1, 1'b0, c);
        run_setting(11'd5, 11'd4, 2'd3, 5'd31, 1, 2, 1'b1, c);

        while (random_items < 560)
        begin
            if (random_items > 373)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (random_items > 187)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 12;
            end
            run_setting(11'($urandom_range(1, 12)), 11'($urandom_range(1, 8)),
                        2'($urandom_range(3)), 5'($urandom_range(31)),
                        $urandom_range(1, 2), $urandom_range(2), $urandom_range(1), c);
            if (random_items == 0) hold_request = 1'b1;
            random_items += c;
        end
        wait_idle();

        $display("ran %0d frames over many sizes, radii and trims; %0d results checked",
                 frames_run, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/atmf_pkg.sv
rtl/core/atmf_queue.sv
rtl/core/atmf_front.sv
rtl/core/atmf_back.sv
rtl/core/alpha_trimmed_mean_filter_top.sv
rtl/core/atmf_checker.sv
tb/alpha_trimmed_mean_filter_top_test.sv
